// ----- hdl/open_address_hash_table_core_defines.svh -----
// Assertion macros for the open-address hash table core.
`ifndef OPEN_ADDRESS_HASH_TABLE_CORE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define OAHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OAHT_ASSERT(lbl, prop, msg)
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/oaht_pkg.sv -----
// Shared constants, codes and control types of the hash table core.
`timescale 1ns / 1ps
package oaht_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 32;
	localparam int SIZE_W      = 11;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int N_MAX       = TABLE_DEPTH / 20;
	localparam int C_W         = $clog2(N_MAX + 1);
	localparam int SUM_W       = $clog2((TABLE_DEPTH - 1) * 31 + N_MAX * N_MAX * 37 + 1);
	localparam int K_W         = $clog2(SUM_W);
	localparam int RECIP_20    = 3277;
	localparam int RECIP_SH    = 16;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_PRESENT = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_MISSING = 2'd3;

	localparam logic [1:0] MARK_EMPTY   = 2'd0;
	localparam logic [1:0] MARK_FILLED  = 2'd1;
	localparam logic [1:0] MARK_DELETED = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_MOD, S_READ, S_CHECK, S_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mod_step;
		logic       set_home;
		logic       walk_home;
		logic       next_probe;
		logic       rd;
		logic       wr_fill;
		logic       wr_del;
		logic       clr_step;
		logic       set_res;
		logic [1:0] res_status;
		logic       res_pos;
	} dp_cmd_t;

	typedef struct packed {
		logic       mod_last;
		logic       clr_last;
		logic [1:0] mark;
		logic       key_hit;
		logic       c_last;
		logic [1:0] cmd;
	} dp_stat_t;
endpackage

// ----- hdl/open_address_hash_table_core.sv -----
// Top level of the open-address hash table core: register port, controller, datapath.
`timescale 1ns / 1ps
`include "open_address_hash_table_core_defines.svh"
// Usage
// - Command channel: drive command, key and home_index with start high; the word is
//   taken at a rising edge where start is high and busy is low. busy stays high until
//   the result has been shown.
// - Result channel: done is high for exactly one cycle with status and slot_index.
//   The receiver cannot hold it off; capture it in that cycle.
// - Register port (APB): table_size at byte address 0, written in the access phase,
//   readable at any time. Change it only while busy is low.
// - Probe cost: each probe costs one slot read, one check and a shift-subtract modulo
//   step; reducing the home index costs a modulo step too. An insert adds a second
//   walk from home. The modulo unit sets the latency: one bit of remainder per cycle.
// - Reset: table_size returns to 1024 and a clearing pass marks all 1024 slots empty,
//   one slot a cycle; busy stays high until the clearing pass ends.
// - One word at a time; a new start is taken the cycle after done.
module open_address_hash_table_core import oaht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] key,
	input  logic [9:0]  home_index,
	output logic        done,
	output logic [1:0]  status,
	output logic [9:0]  slot_index
);
	logic [SIZE_W-1:0] table_size_q;
	dp_cmd_t           dp_cmd;
	dp_stat_t          dp_stat;

	// Register port: one register, written only at address 0; reads ignore the address
	assign pready = 1'b1;
	assign prdata = {{(32-SIZE_W){1'b0}}, table_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_W'(TABLE_DEPTH);
		end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
			table_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// Sequence the walks
	oaht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(dp_cmd), .stat(dp_stat)
	);

	// Hold slot memories, probe arithmetic and result registers
	oaht_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dp_cmd), .stat(dp_stat),
		.table_size(table_size_q), .command(command), .key(key),
		.home_index(home_index), .status(status), .slot_index(slot_index)
	);

	`OAHT_ASSERT(a_done_busy, done |-> busy, "result shown while idle")
	`OAHT_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`OAHT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
	`OAHT_ASSERT(a_full_slot, (done && status == STAT_FULL) |-> (slot_index == 10'd0), "slot index not zero on full")
endmodule

// ----- hdl/oaht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hdl/oaht_dp.sv -----
// Datapath: probe position, modulo unit, slot memories and result registers.
`timescale 1ns / 1ps
module oaht_dp import oaht_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [SIZE_W-1:0]   table_size,
	input  logic [1:0]          command,
	input  logic [31:0]         key,
	input  logic [9:0]          home_index,
	output logic [1:0]          status,
	output logic [9:0]          slot_index
);
	logic [SIZE_W-1:0]        size_q, eff_size;
	logic [C_W-1:0]           n_q, c_q;
	logic [SIZE_W+12-1:0]     n_prod;
	logic [KEY_BITS-1:0]      key_q, key_rd;
	logic [1:0]               cmd_q, mark_rd, mark_wd;
	logic [IDX_W-1:0]         pos_q, home_q, clr_q, mark_wa;
	logic [SUM_W-1:0]         rem_q, rem_next, sq37_q, sq_new, sum_new;
	logic [K_W-1:0]           k_q;
	logic [SIZE_W+SUM_W-1:0]  div_sh;
	logic                     mark_we;

	always_comb begin
		if (table_size == '0) begin
			eff_size = SIZE_W'(1);
		end else if (table_size > SIZE_W'(TABLE_DEPTH)) begin
			eff_size = SIZE_W'(TABLE_DEPTH);
		end else begin
			eff_size = table_size;
		end
	end
	// size / 20 by reciprocal multiplication
	assign n_prod = (SIZE_W+12)'(eff_size) * (SIZE_W+12)'(RECIP_20);

	assign div_sh   = (SIZE_W+SUM_W)'(size_q) << k_q;
	assign rem_next = ((SIZE_W+SUM_W)'(rem_q) >= div_sh) ? rem_q - div_sh[SUM_W-1:0] : rem_q;
	assign sq_new   = sq37_q + SUM_W'(c_q) * SUM_W'(74) + SUM_W'(37);
	assign sum_new  = (SUM_W'(pos_q) << 5) - SUM_W'(pos_q) + sq_new;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q <= eff_size;
			n_q    <= C_W'(n_prod >> RECIP_SH);
			key_q  <= KEY_BITS'(key);
			cmd_q  <= command;
			rem_q  <= SUM_W'(home_index);
			k_q    <= K_W'(SUM_W - 1);
		end else if (cmd.next_probe) begin
			rem_q  <= sum_new;
			k_q    <= K_W'(SUM_W - 1);
			c_q    <= c_q + C_W'(1);
			sq37_q <= sq_new;
		end else if (cmd.mod_step) begin
			rem_q <= rem_next;
			k_q   <= k_q - K_W'(1);
			if (k_q == '0) begin
				pos_q <= rem_next[IDX_W-1:0];
				if (cmd.set_home) begin
					home_q <= rem_next[IDX_W-1:0];
					c_q    <= '0;
					sq37_q <= '0;
				end
			end
		end else if (cmd.walk_home) begin
			pos_q  <= home_q;
			c_q    <= '0;
			sq37_q <= '0;
		end
		if (cmd.set_res) begin
			status     <= cmd.res_status;
			slot_index <= cmd.res_pos ? 10'(pos_q) : 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	assign mark_we = cmd.clr_step | cmd.wr_fill | cmd.wr_del;
	assign mark_wa = cmd.clr_step ? clr_q : pos_q;
	assign mark_wd = cmd.clr_step ? MARK_EMPTY : (cmd.wr_fill ? MARK_FILLED : MARK_DELETED);

	oaht_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk(clk), .we(cmd.wr_fill), .waddr(pos_q), .wdata(key_q),
		.re(cmd.rd), .raddr(pos_q), .rdata(key_rd)
	);
	oaht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_mark_ram (
		.clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
		.re(cmd.rd), .raddr(pos_q), .rdata(mark_rd)
	);

	assign stat.mod_last = (k_q == '0);
	assign stat.clr_last = (clr_q == IDX_W'(TABLE_DEPTH - 1));
	assign stat.mark     = mark_rd;
	assign stat.key_hit  = (key_rd == key_q);
	assign stat.c_last   = (c_q == n_q);
	assign stat.cmd      = cmd_q;
endmodule

// ----- hdl/oaht_ctrl.sv -----
// Controller: sequences the clearing pass, the lookup walk and the insert walk.
`timescale 1ns / 1ps
module oaht_ctrl import oaht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);
	state_t state_q, state_d;
	logic   free_q, free_d, homing_q, homing_d;
	logic   hit, free_slot;

	assign hit       = (stat.mark == MARK_FILLED) && stat.key_hit;
	assign free_slot = (stat.mark == MARK_EMPTY) || (stat.mark == MARK_DELETED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			free_q   <= 1'b0;
			homing_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			free_q   <= free_d;
			homing_q <= homing_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		free_d   = free_q;
		homing_d = homing_q;
		cmd      = '0;
		busy     = (state_q != S_IDLE);
		done     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					free_d   = 1'b0;
					homing_d = 1'b1;
					state_d  = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				cmd.set_home = homing_q;
				if (stat.mod_last) begin
					homing_d = 1'b0;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!free_q) begin
					priority if (hit) begin
						cmd.set_res = 1'b1;
						cmd.res_pos = 1'b1;
						if (stat.cmd == CMD_INSERT) begin
							cmd.res_status = STAT_PRESENT;
						end else begin
							cmd.res_status = STAT_OK;
							cmd.wr_del     = (stat.cmd == CMD_DELETE);
						end
						state_d = S_DONE;
					end else if (stat.mark == MARK_EMPTY || stat.c_last) begin
						if (stat.cmd == CMD_INSERT) begin
							cmd.walk_home = 1'b1;
							free_d        = 1'b1;
							state_d       = S_READ;
						end else begin
							cmd.set_res    = 1'b1;
							cmd.res_status = STAT_MISSING;
							state_d        = S_DONE;
						end
					end else begin
						cmd.next_probe = 1'b1;
						state_d        = S_MOD;
					end
				end else begin
					priority if (free_slot) begin
						cmd.wr_fill    = 1'b1;
						cmd.set_res    = 1'b1;
						cmd.res_pos    = 1'b1;
						cmd.res_status = STAT_OK;
						state_d        = S_DONE;
					end else if (stat.c_last) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = STAT_FULL;
						state_d        = S_DONE;
					end else begin
						cmd.next_probe = 1'b1;
						state_d        = S_MOD;
					end
				end
			end
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
